// ===== sv/fdaf_pkg.sv =====
// shared types and constants for the deframer with address filter and source learning
package fdaf_pkg;

    localparam logic [2:0] EV_HDR_BYTE   = 3'd0;
    localparam logic [2:0] EV_HDR_ACCEPT = 3'd1;
    localparam logic [2:0] EV_HDR_REJECT = 3'd2;
    localparam logic [2:0] EV_DELIVER    = 3'd3;
    localparam logic [2:0] EV_DISCARD    = 3'd4;

    localparam logic [2:0] HDR_LEN    = 3'd0;
    localparam logic [2:0] HDR_CTL_HI = 3'd1;
    localparam logic [2:0] HDR_CTL_LO = 3'd2;
    localparam logic [2:0] HDR_DST_HI = 3'd3;
    localparam logic [2:0] HDR_DST_LO = 3'd4;
    localparam logic [2:0] HDR_SRC_HI = 3'd5;
    localparam logic [2:0] HDR_SRC_LO = 3'd6;

    localparam logic [7:0] CAST_UNI   = 8'h01;
    localparam logic [7:0] CAST_MULTI = 8'h02;
    localparam logic [7:0] CAST_BCAST = 8'hFF;
    localparam logic [7:0] FT_BEACON  = 8'h00;
    localparam logic [7:0] FT_DATA    = 8'h01;
    localparam logic [7:0] FT_ACK     = 8'h02;
    localparam logic [7:0] FT_CMD     = 8'h03;

    // one classified word handed from front to back
    typedef struct packed {
        logic        lookup;
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [7:0]  length;
        logic [15:0] control;
        logic [15:0] dest;
        logic [15:0] source;
        logic        last;
    } word_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  data_byte;
        logic [7:0]  frame_length;
        logic [15:0] frame_control;
        logic [15:0] frame_dest;
        logic [15:0] frame_source;
        logic [1:0]  cast_kind;
        logic [2:0]  frame_kind;
        logic        source_new;
        logic        table_full;
        logic        last_of_frame;
    } result_t;

    function automatic logic [1:0] cast_of(input logic [7:0] hi);
        logic [1:0] c;
        unique case (hi)
            CAST_UNI:   c = 2'd1;
            CAST_MULTI: c = 2'd2;
            CAST_BCAST: c = 2'd3;
            default:    c = 2'd0;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kind_of(input logic [7:0] lo);
        logic [2:0] k;
        unique case (lo)
            FT_BEACON: k = 3'd0;
            FT_DATA:   k = 3'd1;
            FT_ACK:    k = 3'd2;
            FT_CMD:    k = 3'd3;
            default:   k = 3'd4;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/frame_deframer_addr_filter_learn_core.sv =====
// top level of the receive deframer with destination filter and source learning
//
//  channel   signals                          direction
//  config    cfg_we, cfg_wdata                in
//  rx        in_valid/in_ready, rx_byte       in
//  event     out_valid/out_ready, 11 fields   out
//
// header and payload bytes pass through the one-word queue and the result
// register; the last header byte walks the source table in the back end, a ram
// read then a compare per stored entry, before its result is registered.
// reset clears parse state and the table fill count; table contents need no clear.
// the front end fills its one-word queue while the back end stalls, then holds in_ready low.
module frame_deframer_addr_filter_learn_core #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  frame_length,
    output logic [15:0] frame_control,
    output logic [15:0] frame_dest,
    output logic [15:0] frame_source,
    output logic [1:0]  cast_kind,
    output logic [2:0]  frame_kind,
    output logic        source_new,
    output logic        table_full,
    output logic        last_of_frame
);
    import fdaf_pkg::*;

    logic    q_valid, q_ready;
    word_t   q_word;
    result_t res;

    fdaf_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .in_byte(rx_byte),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
    );

    fdaf_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_word(q_word), .out_valid(out_valid), .out_ready(out_ready), .out_res(res)
    );

    assign event_kind     = res.event_kind;
    assign data_byte      = res.data_byte;
    assign frame_length   = res.frame_length;
    assign frame_control  = res.frame_control;
    assign frame_dest     = res.frame_dest;
    assign frame_source   = res.frame_source;
    assign cast_kind      = res.cast_kind;
    assign frame_kind     = res.frame_kind;
    assign source_new     = res.source_new;
    assign table_full     = res.table_full;
    assign last_of_frame  = res.last_of_frame;

`ifndef SYNTHESIS
    a_new_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(source_new && table_full))
        else $error("source_new and table_full together");
    a_flags_on_hdr_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (source_new || table_full)) |->
        (event_kind == EV_HDR_ACCEPT || event_kind == EV_HDR_REJECT))
        else $error("learn flags outside header completion");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(data_byte)))
        else $error("result changed while stalled");
`endif
endmodule

// ===== sv/fdaf_ram.sv =====
// generic single-port ram with registered read
module fdaf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// ===== sv/fdaf_front.sv =====
// front end: header parse, payload phase tracking and destination filter
module fdaf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    output logic          q_valid,
    input  logic          q_ready,
    output fdaf_pkg::word_t q_word
);
    import fdaf_pkg::*;

    logic [15:0] own_reg;
    logic [2:0]  hidx_reg, hidx_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] ctl_reg, ctl_next, dst_reg, dst_next, src_reg, src_next;
    logic        acc_reg, acc_next;
    logic        qv_reg;
    word_t       qw_reg, qw_next;
    logic        take;

    // one-entry queue toward the back end
    assign in_ready = !qv_reg || q_ready;
    assign take     = in_valid && in_ready;
    assign q_valid  = qv_reg;
    assign q_word   = qw_reg;

    always_comb
    begin
        hidx_next = hidx_reg;
        left_next = left_reg;
        len_next  = len_reg;
        ctl_next  = ctl_reg;
        dst_next  = dst_reg;
        src_next  = src_reg;
        acc_next  = acc_reg;
        qw_next   = '0;
        if (left_reg != 8'd0)
        begin
            left_next    = left_reg - 8'd1;
            qw_next.kind = acc_reg ? EV_DELIVER : EV_DISCARD;
            qw_next.last = (left_next == 8'd0);
        end
        else
        begin
            unique case (hidx_reg)
                HDR_LEN:
                begin
                    len_next = in_byte;
                    ctl_next = '0;
                    dst_next = '0;
                    src_next = '0;
                end
                HDR_CTL_HI: ctl_next[15:8] = in_byte;
                HDR_CTL_LO: ctl_next[7:0]  = in_byte;
                HDR_DST_HI: dst_next[15:8] = in_byte;
                HDR_DST_LO: dst_next[7:0]  = in_byte;
                HDR_SRC_HI: src_next[15:8] = in_byte;
                default:    src_next[7:0]  = in_byte;
            endcase
            if (hidx_reg >= HDR_SRC_LO)
            begin
                acc_next       = (dst_next == own_reg);
                qw_next.kind   = acc_next ? EV_HDR_ACCEPT : EV_HDR_REJECT;
                qw_next.lookup = 1'b1;
                hidx_next      = HDR_LEN;
                left_next      = len_next;
                qw_next.last   = (len_next == 8'd0);
            end
            else
            begin
                hidx_next    = hidx_reg + 3'd1;
                qw_next.kind = EV_HDR_BYTE;
            end
        end
        qw_next.data    = in_byte;
        qw_next.length  = len_next;
        qw_next.control = ctl_next;
        qw_next.dest    = dst_next;
        qw_next.source  = src_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg  <= '0;
            hidx_reg <= HDR_LEN;
            left_reg <= '0;
            len_reg  <= '0;
            ctl_reg  <= '0;
            dst_reg  <= '0;
            src_reg  <= '0;
            acc_reg  <= 1'b0;
            qv_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                own_reg <= cfg_wdata;
            if (take)
            begin
                hidx_reg <= hidx_next;
                left_reg <= left_next;
                len_reg  <= len_next;
                ctl_reg  <= ctl_next;
                dst_reg  <= dst_next;
                src_reg  <= src_next;
                acc_reg  <= acc_next;
                qv_reg   <= 1'b1;
            end
            else if (q_ready)
                qv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            qw_reg <= qw_next;
    end
endmodule

// ===== sv/fdaf_back.sv =====
// back end: source table walk and append, result register
module fdaf_back #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  fdaf_pkg::word_t q_word,
    output logic            out_valid,
    input  logic            out_ready,
    output fdaf_pkg::result_t out_res
);
    import fdaf_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  idx_reg, idx_next;
    word_t       w_reg;
    logic        ov_reg, ov_next;
    result_t     res_reg;
    logic        set_res, res_new, res_full;
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0] ram_rdata;

    fdaf_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_table (
        .clk(clk), .we(ram_we), .addr(ram_addr),
        .wdata(w_reg.source), .rdata(ram_rdata)
    );

    assign out_valid = ov_reg;
    assign out_res   = res_reg;
    // take a word only when idle and the result slot is empty or frees up this cycle
    assign q_ready = (state_reg == ST_IDLE) && (!ov_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg && !out_ready;
        set_res    = 1'b0;
        res_new    = 1'b0;
        res_full   = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = idx_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && q_ready && q_word.lookup)
                begin
                    state_next = ST_READ;
                    idx_next   = '0;
                end
            end
            ST_READ:
            begin
                if (idx_reg >= count_reg)
                begin
                    // miss: append or flag a full table
                    if (count_reg < 8'(TABLE_DEPTH))
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 8'd1;
                        res_new    = 1'b1;
                    end
                    else
                        res_full = 1'b1;
                    state_next = ST_OUT;
                end
                else
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (ram_rdata == w_reg.source)
                    state_next = ST_OUT;
                else
                begin
                    idx_next   = idx_reg + 8'd1;
                    state_next = ST_READ;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_IDLE && q_valid && q_ready && !q_word.lookup)
            ov_next = 1'b1;
        set_res = 1'b1;
    end

    logic new_hold_reg, full_hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            ov_reg        <= 1'b0;
            new_hold_reg  <= 1'b0;
            full_hold_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
            if (state_reg == ST_IDLE)
            begin
                new_hold_reg  <= 1'b0;
                full_hold_reg <= 1'b0;
            end
            else if (res_new || res_full)
            begin
                new_hold_reg  <= res_new;
                full_hold_reg <= res_full;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && q_ready)
            w_reg <= q_word;
        if (set_res && state_reg == ST_IDLE && q_valid && q_ready && !q_word.lookup)
        begin
            res_reg.event_kind     <= q_word.kind;
            res_reg.data_byte      <= q_word.data;
            res_reg.frame_length   <= q_word.length;
            res_reg.frame_control  <= q_word.control;
            res_reg.frame_dest     <= q_word.dest;
            res_reg.frame_source   <= q_word.source;
            res_reg.cast_kind      <= cast_of(q_word.control[15:8]);
            res_reg.frame_kind     <= kind_of(q_word.control[7:0]);
            res_reg.source_new     <= 1'b0;
            res_reg.table_full     <= 1'b0;
            res_reg.last_of_frame  <= q_word.last;
        end
        else if (state_reg == ST_OUT && (!ov_reg || out_ready))
        begin
            res_reg.event_kind     <= w_reg.kind;
            res_reg.data_byte      <= w_reg.data;
            res_reg.frame_length   <= w_reg.length;
            res_reg.frame_control  <= w_reg.control;
            res_reg.frame_dest     <= w_reg.dest;
            res_reg.frame_source   <= w_reg.source;
            res_reg.cast_kind      <= cast_of(w_reg.control[15:8]);
            res_reg.frame_kind     <= kind_of(w_reg.control[7:0]);
            res_reg.source_new     <= new_hold_reg;
            res_reg.table_full     <= full_hold_reg;
            res_reg.last_of_frame  <= w_reg.last;
        end
    end
endmodule
